// File: rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on the rising clock edge, off while reset is asserted
`define BQL_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// property checked on every rising clock edge, reset included
`define BQL_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

// File: rtl/bql_pkg.sv
// shared constants and register index codes of the biquad lowpass unit
`default_nettype none

package bql_pkg;

  localparam int COUNT_W   = 8;
  localparam int CFG_IDX_W = 3;
  localparam logic [COUNT_W-1:0] WARMUP_RESET = 8'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_B0     = 3'd0,
    REG_B1     = 3'd1,
    REG_B2     = 3'd2,
    REG_A1     = 3'd3,
    REG_A2     = 3'd4,
    REG_WARMUP = 3'd5
  } reg_idx_t;

endpackage

`default_nettype wire

// File: rtl/biquad_lowpass_with_warmup_unit.sv
// biquad lowpass filter top level with warm-up pass-through
//
//   channel | direction | handshake          | payload
//   in      | sink      | in_valid/in_stall  | in_sample_in
//   out     | source    | out_valid/out_stall| out_sample_out, out_settled
//   cfg     | sink      | cfg_wr_en          | cfg_idx, cfg_wdata
//
// one sample per cycle while the output is not stalled; a sample passes the input and result registers
// the input register feeds the multiply-add, whose result is written into the result
// register and into the output history in the same cycle
// the input side stalls only while the result register is full and stalled
// synchronous active-low reset restores coefficient defaults and clears history
`default_nettype none

module biquad_lowpass_with_warmup_unit #(
  parameter int SAMPLE_BITS    = 16,
  parameter int COEF_FRAC_BITS = 16,
  localparam int CoefW = COEF_FRAC_BITS + 2,
  localparam int CfgW  = (CoefW > bql_pkg::COUNT_W) ? CoefW : bql_pkg::COUNT_W
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [SAMPLE_BITS-1:0]   in_sample_in,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [SAMPLE_BITS-1:0]   out_sample_out,
  output logic                            out_settled,
  input  logic                            cfg_wr_en,
  input  logic [bql_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [CfgW-1:0]                 cfg_wdata
);

  import bql_pkg::*;

  localparam logic signed [CoefW-1:0] B0Reset = CoefW'(1) << COEF_FRAC_BITS;

  logic signed [CoefW-1:0]       b0_r, b1_r, b2_r, a1_r, a2_r;
  logic [COUNT_W-1:0]            warmup_count_r;
  logic [COUNT_W-1:0]            cnt_r;
  logic signed [SAMPLE_BITS-1:0] x1_r, x2_r, y1_r, y2_r;
  logic                          in_vld_r;
  logic signed [SAMPLE_BITS-1:0] in_x_r;
  logic                          out_vld_r;
  logic signed [SAMPLE_BITS-1:0] out_y_r;
  logic                          out_settled_r;

  logic                          adv;
  logic                          settled;
  logic signed [SAMPLE_BITS-1:0] y_mac;
  logic signed [SAMPLE_BITS-1:0] y_nxt;

  // move the held sample into the result register
  assign adv      = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !adv;
  assign settled  = (cnt_r >= warmup_count_r);
  assign y_nxt    = settled ? y_mac : in_x_r;

  bql_mac #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_mac (
    .x (in_x_r),
    .x1(x1_r),
    .x2(x2_r),
    .y1(y1_r),
    .y2(y2_r),
    .b0(b0_r),
    .b1(b1_r),
    .b2(b2_r),
    .a1(a1_r),
    .a2(a2_r),
    .y (y_mac)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_r           <= B0Reset;
      b1_r           <= '0;
      b2_r           <= '0;
      a1_r           <= '0;
      a2_r           <= '0;
      warmup_count_r <= WARMUP_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_idx)
        REG_B0:     b0_r           <= cfg_wdata[CoefW-1:0];
        REG_B1:     b1_r           <= cfg_wdata[CoefW-1:0];
        REG_B2:     b2_r           <= cfg_wdata[CoefW-1:0];
        REG_A1:     a1_r           <= cfg_wdata[CoefW-1:0];
        REG_A2:     a2_r           <= cfg_wdata[CoefW-1:0];
        REG_WARMUP: warmup_count_r <= cfg_wdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_x_r <= in_sample_in;
    end
  end

  // histories advance with each transaction; the warm-up counter until settled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x1_r  <= '0;
      x2_r  <= '0;
      y1_r  <= '0;
      y2_r  <= '0;
      cnt_r <= '0;
    end else if (adv) begin
      x1_r <= in_x_r;
      x2_r <= x1_r;
      y1_r <= y_nxt;
      y2_r <= y1_r;
      if (!settled) begin
        cnt_r <= cnt_r + COUNT_W'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_y_r       <= y_nxt;
      out_settled_r <= settled;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_sample_out = out_y_r;
  assign out_settled    = out_settled_r;

endmodule

`default_nettype wire

// File: rtl/bql_mac.sv
// five-tap biquad sum with rounding and saturation
`default_nettype none

module bql_mac #(
  parameter int SAMPLE_BITS    = 16,
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic signed [SAMPLE_BITS-1:0]    x,
  input  logic signed [SAMPLE_BITS-1:0]    x1,
  input  logic signed [SAMPLE_BITS-1:0]    x2,
  input  logic signed [SAMPLE_BITS-1:0]    y1,
  input  logic signed [SAMPLE_BITS-1:0]    y2,
  input  logic signed [COEF_FRAC_BITS+1:0] b0,
  input  logic signed [COEF_FRAC_BITS+1:0] b1,
  input  logic signed [COEF_FRAC_BITS+1:0] b2,
  input  logic signed [COEF_FRAC_BITS+1:0] a1,
  input  logic signed [COEF_FRAC_BITS+1:0] a2,
  output logic signed [SAMPLE_BITS-1:0]    y
);

  localparam int CoefW = COEF_FRAC_BITS + 2;
  localparam int ProdW = CoefW + SAMPLE_BITS;
  localparam int AccW  = ProdW + 3;
  localparam logic signed [AccW-1:0] Half =
    {{(AccW-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}};
  localparam logic signed [AccW-1:0] YMax =
    {{(AccW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [AccW-1:0] YMin =
    {{(AccW-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

  logic signed [ProdW-1:0] p0, p1, p2, p3, p4;
  logic signed [AccW-1:0]  acc;
  logic signed [AccW-1:0]  shifted;

  assign p0 = b0 * x;
  assign p1 = b1 * x1;
  assign p2 = b2 * x2;
  assign p3 = a1 * y1;
  assign p4 = a2 * y2;

  assign acc = AccW'(p0) + AccW'(p1) + AccW'(p2) - AccW'(p3) - AccW'(p4);

  // round half up, then floor shift
  assign shifted = (acc + Half) >>> COEF_FRAC_BITS;

  always_comb begin
    if (shifted > YMax) begin
      y = YMax[SAMPLE_BITS-1:0];
    end else if (shifted < YMin) begin
      y = YMin[SAMPLE_BITS-1:0];
    end else begin
      y = shifted[SAMPLE_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

// File: rtl/bql_checker.sv
// port-level checker for the biquad lowpass unit and its bind
`default_nettype none

`include "assert_macros.svh"

module bql_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  input  wire                     in_stall,
  input  wire                     out_valid,
  input  wire                     out_stall,
  input  wire [SAMPLE_BITS-1:0]   out_sample_out,
  input  wire                     out_settled
);

  // a stalled result keeps its valid and its payload
  `BQL_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_sample_out) && $stable(out_settled))

  // input stalls only behind a full, stalled result register
  `BQL_ASSERT(a_in_stall_cause, clk, rst_n, in_stall |-> out_valid && out_stall)

  // a new result follows an input transaction through the input and result registers
  `BQL_ASSERT(a_out_from_in, clk, rst_n, $rose(out_valid) |-> $past(in_valid && !in_stall, 2))

  // reset empties the result register
  `BQL_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid)

endmodule

bind biquad_lowpass_with_warmup_unit bql_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_bql_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_sample_out(out_sample_out),
  .out_settled   (out_settled)
);

`default_nettype wire
